// File: rtl/fdtm_pkg.sv
`default_nettype none
package fdtm_pkg;

  localparam int WW = 10;
  localparam int HW = 9;
  localparam int TW = 8;
  localparam int PIX_W = 8;
  localparam int SUM_W = 24;
  localparam int IDX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SETTLE_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd2;

  localparam logic [WW-1:0] RST_FRAME_WIDTH      = 10'd640;
  localparam logic [HW-1:0] RST_FRAME_HEIGHT     = 9'd480;
  localparam logic [TW-1:0] RST_MOTION_THRESHOLD = 8'd4;

  localparam logic [WW-1:0] MIN_WIDTH  = 10'd3;
  localparam logic [HW-1:0] MIN_HEIGHT = 9'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // cycles for the derived tile geometry to follow a register write
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage
`default_nettype wire

// File: rtl/fdtm_if.sv
`default_nettype none
interface fdtm_in_if;
  logic                         valid;
  logic                         ready;
  logic [fdtm_pkg::PIX_W-1:0]   pixel_value;
  logic                         frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink (input valid, pixel_value, frame_start, output ready);
endinterface

interface fdtm_out_if;
  logic                         valid;
  logic                         ready;
  logic [fdtm_pkg::IDX_W-1:0]   tile_index;
  logic                         motion_flag;
  logic                         last_tile;
  modport source (output valid, tile_index, motion_flag, last_tile, input ready);
  modport sink (input valid, tile_index, motion_flag, last_tile, output ready);
endinterface

interface fdtm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fdtm_pkg::CFG_IDX_W-1:0]    index;
  logic [fdtm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/fdtm_ram.sv
`default_nettype none
module fdtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read of the entry being written returns the old value
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/frame_diff_tile_motion_trigger.sv
// Frame-difference motion trigger. Pixels (green value, raster order, frame_start on the first
// pixel of a frame) are differenced against the same position of the previous frame, held in a
// MAX_WIDTH*MAX_HEIGHT byte memory, and the absolute differences are summed per tile of a
// TILES_X by TILES_Y grid; edge pixels outside whole tiles are only stored. After the last pixel
// of a frame one item per tile comes out in row-major order, motion_flag set when the tile sum
// exceeds motion_threshold times the tile pixel count, last_tile on the final one. Each pixel
// goes through accept, address multiply, frame memory read and read-modify-write of the tile
// sum memory before the next one is accepted; at frame end each tile result passes through the
// tile sum memory read port and waits while the output register is full, and the input is taken
// again once the last result sits in the output register. After reset a clearing pass writes
// zero to every frame memory entry, with no pixel accepted meanwhile. After each configuration
// write the input is held off while the tile geometry is recomputed.
`default_nettype none
module frame_diff_tile_motion_trigger #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int TILES_X    = 3,
  parameter int TILES_Y    = 3
) (
  input wire logic     clk,
  input wire logic     rst_n,
  fdtm_in_if.sink      in_ch,
  fdtm_out_if.source   out_ch,
  fdtm_cfg_if.sink     cfg_ch
);

  localparam int WW = fdtm_pkg::WW;
  localparam int HW = fdtm_pkg::HW;
  localparam int TW = fdtm_pkg::TW;
  localparam int PIX_W = fdtm_pkg::PIX_W;
  localparam int SUM_W = fdtm_pkg::SUM_W;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW = WW + HW + 1;
  localparam int TILE_COUNT = TILES_X * TILES_Y;
  localparam int KW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int TXW = $clog2(TILES_X + 1);
  localparam int TYW = $clog2(TILES_Y + 1);
  localparam int SX = WW + 3;
  localparam int SY = HW + 3;
  localparam int MXW = SX + 1;
  localparam int MYW = SY + 1;
  localparam int RX = (2 ** SX + TILES_X - 1) / TILES_X;
  localparam int RY = (2 ** SY + TILES_Y - 1) / TILES_Y;
  localparam int CNT_W = WW + HW;
  localparam int LIM_W = CNT_W + TW;
  localparam int CMP_W = (LIM_W > SUM_W) ? LIM_W : SUM_W;
  localparam int W_LIM = (MAX_WIDTH < 2 ** WW) ? MAX_WIDTH : 2 ** WW - 1;
  localparam int H_LIM = (MAX_HEIGHT < 2 ** HW) ? MAX_HEIGHT : 2 ** HW - 1;

  localparam logic [MXW-1:0] RECIP_X = MXW'(RX);
  localparam logic [MYW-1:0] RECIP_Y = MYW'(RY);
  localparam logic [WW-1:0]  W_MAX = WW'(W_LIM);
  localparam logic [HW-1:0]  H_MAX = HW'(H_LIM);
  localparam logic [AW-1:0]  CLR_LAST = AW'(STORE_DEPTH - 1);
  localparam logic [KW-1:0]  K_LAST = KW'(TILE_COUNT - 1);

  // configuration registers
  logic [WW-1:0] frame_width_r;
  logic [HW-1:0] frame_height_r;
  logic [TW-1:0] motion_threshold_r;
  logic [fdtm_pkg::SETTLE_W-1:0] settle_r;
  logic cfg_acc;

  // derived tile geometry
  logic [WW-1:0]      w_c_r;
  logic [HW-1:0]      h_c_r;
  logic [WW+MXW-1:0]  tw_prod_r;
  logic [HW+MYW-1:0]  th_prod_r;
  logic [WW-1:0]      tw_r;
  logic [HW-1:0]      th_r;
  logic [WW-1:0]      xb_r [1:TILES_X];
  logic [HW-1:0]      yb_r [1:TILES_Y];
  logic [CNT_W-1:0]   count_r;
  logic [LIM_W-1:0]   limit_r;

  // control
  fdtm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r;
  logic [WW-1:0]     col_r;
  logic [HW-1:0]     row_r;
  logic [TILE_COUNT-1:0] tvalid_r;
  logic [KW-1:0]     emit_k_r;
  logic              out_valid_r;

  // payload
  logic [PIX_W-1:0]  pix_r;
  logic [PW-1:0]     prod_r;
  logic              in_range_r;
  logic [KW-1:0]     tile_k_r;
  logic              tile_in_r;
  logic [KW-1:0]     out_k_r;
  logic              out_flag_r;
  logic              out_last_r;

  // strobes and datapath
  logic              in_ready;
  logic              in_acc;
  logic              out_free;
  logic              load_out;
  logic              emit_last;
  logic              clr_last;
  logic              frame_end;
  logic              wrap_col;
  logic              wrap_row;
  logic [WW:0]       col_inc;
  logic [HW:0]       row_inc;
  logic [PW-1:0]     addr_full;
  logic              in_range;
  logic [TXW-1:0]    tx_cnt;
  logic [TYW-1:0]    ty_cnt;
  logic              in_x;
  logic              in_y;
  logic [KW-1:0]     tile_k_nxt;

  logic              frame_we;
  logic [AW-1:0]     frame_waddr;
  logic [PIX_W-1:0]  frame_wdata;
  logic [AW-1:0]     frame_raddr;
  logic [PIX_W-1:0]  frame_rdata;

  logic              tile_we;
  logic [KW-1:0]     tile_raddr;
  logic [SUM_W-1:0]  tile_wdata;
  logic [SUM_W-1:0]  tile_rdata;
  logic [SUM_W-1:0]  tile_old;
  logic [SUM_W:0]    tile_sum;
  logic [PIX_W-1:0]  old_pix;
  logic [PIX_W-1:0]  diff;
  logic [SUM_W-1:0]  emit_sum;

  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r      <= fdtm_pkg::RST_FRAME_WIDTH;
      frame_height_r     <= fdtm_pkg::RST_FRAME_HEIGHT;
      motion_threshold_r <= fdtm_pkg::RST_MOTION_THRESHOLD;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        fdtm_pkg::REG_FRAME_WIDTH:      frame_width_r <= cfg_ch.data[WW-1:0];
        fdtm_pkg::REG_FRAME_HEIGHT:     frame_height_r <= cfg_ch.data[HW-1:0];
        fdtm_pkg::REG_MOTION_THRESHOLD: motion_threshold_r <= cfg_ch.data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= fdtm_pkg::SETTLE_CYCLES;
    end else if (cfg_acc) begin
      settle_r <= fdtm_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // tile geometry pipeline, tile width by reciprocal multiply
  always_ff @(posedge clk) begin
    if (frame_width_r < fdtm_pkg::MIN_WIDTH) begin
      w_c_r <= fdtm_pkg::MIN_WIDTH;
    end else if (frame_width_r > W_MAX) begin
      w_c_r <= W_MAX;
    end else begin
      w_c_r <= frame_width_r;
    end
    if (frame_height_r < fdtm_pkg::MIN_HEIGHT) begin
      h_c_r <= fdtm_pkg::MIN_HEIGHT;
    end else if (frame_height_r > H_MAX) begin
      h_c_r <= H_MAX;
    end else begin
      h_c_r <= frame_height_r;
    end
    tw_prod_r <= (WW+MXW)'(w_c_r) * (WW+MXW)'(RECIP_X);
    th_prod_r <= (HW+MYW)'(h_c_r) * (HW+MYW)'(RECIP_Y);
    tw_r <= tw_prod_r[SX +: WW];
    th_r <= th_prod_r[SY +: HW];
    for (int k = 1; k <= TILES_X; k++) begin
      xb_r[k] <= WW'(k * 32'(tw_r));
    end
    for (int k = 1; k <= TILES_Y; k++) begin
      yb_r[k] <= HW'(k * 32'(th_r));
    end
    count_r <= CNT_W'(tw_r) * CNT_W'(th_r);
    limit_r <= LIM_W'(motion_threshold_r) * LIM_W'(count_r);
  end

  // tile of the current position
  always_comb begin
    tx_cnt = '0;
    for (int k = 1; k < TILES_X; k++) begin
      if (col_r >= xb_r[k]) begin
        tx_cnt = tx_cnt + TXW'(1);
      end
    end
    ty_cnt = '0;
    for (int k = 1; k < TILES_Y; k++) begin
      if (row_r >= yb_r[k]) begin
        ty_cnt = ty_cnt + TYW'(1);
      end
    end
    in_x = col_r < xb_r[TILES_X];
    in_y = row_r < yb_r[TILES_Y];
    tile_k_nxt = KW'(32'(ty_cnt) * TILES_X + 32'(tx_cnt));
  end

  // position advance
  always_comb begin
    col_inc   = {1'b0, col_r} + 1'b1;
    row_inc   = {1'b0, row_r} + 1'b1;
    wrap_col  = col_inc >= {1'b0, w_c_r};
    wrap_row  = row_inc >= {1'b0, h_c_r};
    frame_end = wrap_col && wrap_row;
  end

  assign addr_full = prod_r + PW'(col_r);
  assign in_range  = 32'(addr_full) < STORE_DEPTH;
  assign clr_last  = clr_cnt_r == CLR_LAST;
  assign emit_last = emit_k_r == K_LAST;

  // difference and saturating tile sum
  always_comb begin
    old_pix   = in_range_r ? frame_rdata : '0;
    diff      = (pix_r > old_pix) ? pix_r - old_pix : old_pix - pix_r;
    tile_old  = tvalid_r[tile_k_r] ? tile_rdata : '0;
    tile_sum  = {1'b0, tile_old} + (SUM_W+1)'(diff);
    tile_wdata = tile_sum[SUM_W] ? fdtm_pkg::SUM_MAX : tile_sum[SUM_W-1:0];
    emit_sum  = tvalid_r[emit_k_r] ? tile_rdata : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fdtm_pkg::ST_CLEAR:   if (clr_last) state_nxt = fdtm_pkg::ST_IDLE;
      fdtm_pkg::ST_IDLE:    if (in_acc) state_nxt = fdtm_pkg::ST_ADDR;
      fdtm_pkg::ST_ADDR:    state_nxt = fdtm_pkg::ST_RD;
      fdtm_pkg::ST_RD:      state_nxt = fdtm_pkg::ST_ACC;
      fdtm_pkg::ST_ACC: begin
        state_nxt = frame_end ? fdtm_pkg::ST_EMIT_RD : fdtm_pkg::ST_IDLE;
      end
      fdtm_pkg::ST_EMIT_RD: state_nxt = fdtm_pkg::ST_EMIT_WR;
      fdtm_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          state_nxt = emit_last ? fdtm_pkg::ST_IDLE : fdtm_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = fdtm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    frame_we    = 1'b0;
    frame_waddr = AW'(addr_full);
    frame_wdata = pix_r;
    frame_raddr = AW'(addr_full);
    tile_we     = 1'b0;
    tile_raddr  = tile_k_r;
    load_out    = 1'b0;
    unique case (state_r)
      fdtm_pkg::ST_CLEAR: begin
        frame_we    = 1'b1;
        frame_waddr = clr_cnt_r;
        frame_wdata = '0;
      end
      fdtm_pkg::ST_IDLE:    in_ready = settle_r == '0;
      fdtm_pkg::ST_ADDR:    ;
      fdtm_pkg::ST_RD:      frame_we = in_range;
      fdtm_pkg::ST_ACC:     tile_we = tile_in_r;
      fdtm_pkg::ST_EMIT_RD: tile_raddr = emit_k_r;
      fdtm_pkg::ST_EMIT_WR: begin
        tile_raddr = emit_k_r;
        load_out   = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdtm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      tvalid_r    <= '0;
      emit_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fdtm_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_acc && in_ch.frame_start) begin
        col_r    <= '0;
        row_r    <= '0;
        tvalid_r <= '0;
      end
      if (state_r == fdtm_pkg::ST_ACC) begin
        if (tile_in_r) begin
          tvalid_r[tile_k_r] <= 1'b1;
        end
        if (wrap_col) begin
          col_r <= '0;
          row_r <= wrap_row ? '0 : row_inc[HW-1:0];
        end else begin
          col_r <= col_inc[WW-1:0];
        end
        emit_k_r <= '0;
      end
      if (load_out) begin
        emit_k_r <= emit_k_r + 1'b1;
        if (emit_last) begin
          tvalid_r <= '0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_ch.pixel_value;
    end
    if (state_r == fdtm_pkg::ST_ADDR) begin
      prod_r    <= PW'(row_r) * PW'(w_c_r);
      tile_k_r  <= tile_k_nxt;
      tile_in_r <= in_x && in_y;
    end
    if (state_r == fdtm_pkg::ST_RD) begin
      in_range_r <= in_range;
    end
    if (load_out) begin
      out_k_r    <= emit_k_r;
      out_flag_r <= CMP_W'(emit_sum) > CMP_W'(limit_r);
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tile_index  = fdtm_pkg::IDX_W'(out_k_r);
  assign out_ch.motion_flag = out_flag_r;
  assign out_ch.last_tile   = out_last_r;

  fdtm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  fdtm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (TILE_COUNT)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_k_r),
    .wdata (tile_wdata),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

  a_accept_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == fdtm_pkg::ST_ADDR)
    else $error("accepted item did not move to address stage");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_ready)
    else $error("input taken before tile geometry settled");

  a_last_on_final_tile: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_k_r == K_LAST)))
    else $error("last_tile out of step with tile index");

  a_tile_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    tile_we |-> 32'(tile_k_r) < TILE_COUNT)
    else $error("tile sum write outside the grid");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fdtm_pkg::ST_CLEAR |-> !out_valid_r)
    else $error("result shown during clearing pass");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_W = 640;
  localparam int MAX_H = 480;
  localparam int TILES_X = 3;
  localparam int TILES_Y = 3;
  localparam int TILE_NUM = TILES_X * TILES_Y;
  localparam int STORE_DEPTH = MAX_W * MAX_H;
  localparam int RANDOM_PIXELS = 140;
  localparam int WATCHDOG_LIMIT = 1000000;

  typedef struct packed {
    logic [fdtm_pkg::IDX_W-1:0] tile_index;
    logic                       motion_flag;
    logic                       last_tile;
  } tile_flag_t;

  logic clk;
  logic rst_n;

  fdtm_in_if  in_if ();
  fdtm_out_if out_if ();
  fdtm_cfg_if cfg_if ();

  frame_diff_tile_motion_trigger #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .TILES_X    (TILES_X),
    .TILES_Y    (TILES_Y)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // model of the block
  bit [fdtm_pkg::PIX_W-1:0] prev_frame [STORE_DEPTH];
  bit [fdtm_pkg::SUM_W-1:0] tile_sum [TILE_NUM];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [fdtm_pkg::WW-1:0] cfg_width;
  logic [fdtm_pkg::HW-1:0] cfg_height;
  logic [fdtm_pkg::TW-1:0] cfg_threshold;
  bit frame_closed;

  tile_flag_t expected_tiles [$];
  int failures;
  int pixels_sent;
  int idle_cycles;
  bit gaps_on;
  bit stall_on;
  int burst_left;
  logic [15:0] ready_pattern;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(cfg_width);
    if (w < 32'(fdtm_pkg::MIN_WIDTH)) return 32'(fdtm_pkg::MIN_WIDTH);
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(cfg_height);
    if (h < 32'(fdtm_pkg::MIN_HEIGHT)) return 32'(fdtm_pkg::MIN_HEIGHT);
    if (h > MAX_H) return MAX_H;
    return h;
  endfunction

  task automatic predict_tile_flags(input logic [fdtm_pkg::PIX_W-1:0] pv, input logic fs);
    int unsigned w, h, tw, th, addr, p, old_pix, diff, tx, ty, k, s, limit;
    tile_flag_t r;
    w = eff_width();
    h = eff_height();
    tw = w / TILES_X;
    th = h / TILES_Y;
    p = 32'(pv);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      foreach (tile_sum[i]) tile_sum[i] = '0;
    end
    addr = row_pos * w + col_pos;
    old_pix = 0;
    if (addr < STORE_DEPTH) begin
      old_pix = 32'(prev_frame[addr]);
      prev_frame[addr] = pv;
    end
    diff = (p > old_pix) ? p - old_pix : old_pix - p;
    if (tw != 0 && th != 0) begin
      tx = col_pos / tw;
      ty = row_pos / th;
      if (tx < TILES_X && ty < TILES_Y) begin
        k = ty * TILES_X + tx;
        s = 32'(tile_sum[k]) + diff;
        tile_sum[k] = (s > 32'(fdtm_pkg::SUM_MAX)) ? fdtm_pkg::SUM_MAX :
                      s[fdtm_pkg::SUM_W-1:0];
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        limit = 32'(cfg_threshold) * tw * th;
        for (k = 0; k < TILE_NUM; k++) begin
          r.tile_index = k[fdtm_pkg::IDX_W-1:0];
          r.motion_flag = 32'(tile_sum[k]) > limit;
          r.last_tile = (k == TILE_NUM - 1);
          expected_tiles = {expected_tiles, r};
          tile_sum[k] = '0;
        end
        frame_closed = 1'b1;
      end
    end
  endtask

  task automatic send_pixel(input logic [fdtm_pkg::PIX_W-1:0] pv, input logic fs);
    if (gaps_on && burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = int'($urandom_range(1, 24));
    end
    if (burst_left > 0) burst_left--;
    in_if.valid <= 1'b1;
    in_if.pixel_value <= pv;
    in_if.frame_start <= fs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_tile_flags(pv, fs);
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    // a pixel that closes no frame may still be in the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [fdtm_pkg::WW-1:0] w,
                              input logic [fdtm_pkg::HW-1:0] h,
                              input logic [fdtm_pkg::TW-1:0] thr);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= fdtm_pkg::REG_FRAME_WIDTH;
    cfg_if.data <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_width = w;
    cfg_if.index <= fdtm_pkg::REG_FRAME_HEIGHT;
    cfg_if.data <= fdtm_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_height = h;
    cfg_if.index <= fdtm_pkg::REG_MOTION_THRESHOLD;
    cfg_if.data <= fdtm_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_threshold = thr;
    cfg_if.valid <= 1'b0;
  endtask

  // tiles marked as moving get fresh values, the rest drift slightly
  task automatic send_frame(input bit with_start, input bit abort, input bit noisy);
    int unsigned w, h, c, r, tx, ty, addr;
    int n, abort_at, v;
    bit [TILE_NUM-1:0] moving;
    logic fs;
    logic [fdtm_pkg::PIX_W-1:0] pv;
    w = eff_width();
    h = eff_height();
    moving = TILE_NUM'($urandom);
    abort_at = abort ? int'($urandom_range(1, w * h - 1)) : -1;
    frame_closed = 1'b0;
    n = 0;
    while (!frame_closed && n != abort_at) begin
      fs = (n == 0 && with_start) || (noisy && $urandom_range(0, 199) == 0);
      c = fs ? 0 : col_pos;
      r = fs ? 0 : row_pos;
      tx = c / (w / TILES_X);
      ty = r / (h / TILES_Y);
      addr = r * w + c;
      if (tx >= TILES_X || ty >= TILES_Y || moving[ty * TILES_X + tx] ||
          addr >= STORE_DEPTH) begin
        pv = 8'($urandom_range(0, 255));
      end else begin
        v = int'(prev_frame[addr]) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        pv = v[fdtm_pkg::PIX_W-1:0];
      end
      send_pixel(pv, fs);
      n++;
    end
  endtask

  // a frame left open, to be closed after a geometry change
  task automatic send_run(input int count, input bit with_start);
    for (int n = 0; n < count; n++) begin
      send_pixel(8'($urandom_range(0, 255)), with_start && n == 0);
    end
  endtask

  task automatic test_reset_geometry();
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b0);
  endtask

  task automatic test_tiny_frames();
    logic [fdtm_pkg::PIX_W-1:0] frame_a [9];
    frame_a = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd0, 8'd255};
    // width and height below the minimum, column already past the new width
    set_geometry(10'd0, 9'd2, 8'd0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd17, 1'b0);
    foreach (frame_a[i]) send_pixel(frame_a[i], i == 0);
    set_geometry(10'd2, 9'd0, 8'd255);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
  endtask

  task automatic test_random_frames();
    int start_count;
    int phase;
    logic [fdtm_pkg::WW-1:0] w;
    logic [fdtm_pkg::HW-1:0] h;
    logic [fdtm_pkg::TW-1:0] thr;
    start_count = pixels_sent;
    phase = 0;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      case ($urandom_range(0, 5))
        0: w = 10'($urandom_range(0, 2));
        1: w = 10'($urandom_range(13, 24));
        default: w = 10'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 5))
        0: h = 9'($urandom_range(0, 2));
        1: h = 9'($urandom_range(10, 16));
        default: h = 9'($urandom_range(3, 9));
      endcase
      case ($urandom_range(0, 5))
        0: thr = 8'd0;
        1: thr = 8'd255;
        2, 3: thr = 8'($urandom_range(1, 8));
        4: thr = 8'($urandom_range(60, 110));
        default: thr = 8'($urandom);
      endcase
      set_geometry(w, h, thr);
      gaps_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) begin
        send_frame($urandom_range(0, 6) != 0, $urandom_range(0, 9) == 0, 1'b1);
      end
      if (phase == 0 || $urandom_range(0, 4) == 0) drain_results();
      phase++;
    end
  endtask

  task automatic test_large_frames();
    gaps_on = 1'b0;
    stall_on = 1'b1;
    // widest line reaches the second tile column, then closed at a small size
    set_geometry(10'h3FF, 9'd0, 8'($urandom_range(0, 20)));
    send_run(230, 1'b1);
    set_geometry(10'd3, 9'd3, 8'($urandom_range(0, 20)));
    send_frame(1'b0, 1'b0, 1'b0);
    // tallest frame, row already past the new height
    set_geometry(10'd0, 9'h1FF, 8'($urandom_range(0, 20)));
    send_run(40, 1'b1);
    set_geometry(10'd5, 9'd4, 8'($urandom_range(0, 20)));
    send_frame(1'b0, 1'b0, 1'b0);
  endtask

  initial begin
    cfg_width = fdtm_pkg::RST_FRAME_WIDTH;
    cfg_height = fdtm_pkg::RST_FRAME_HEIGHT;
    cfg_threshold = fdtm_pkg::RST_MOTION_THRESHOLD;
    col_pos = 0;
    row_pos = 0;
    failures = 0;
    pixels_sent = 0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    burst_left = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.pixel_value <= '0;
    in_if.frame_start <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= fdtm_pkg::REG_FRAME_WIDTH;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_tiny_frames();
    test_random_frames();
    test_large_frames();

    drain_results();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    ready_pattern = 16'hB4C3;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready && out_if.last_tile) begin
        ready_pattern = 16'($urandom) | 16'h0101;
      end
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      out_if.ready <= !stall_on || ready_pattern[0];
    end
  end

  always @(posedge clk) begin : check_tiles
    tile_flag_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_tiles.size() == 0) begin
        $error("tile_index: expected none, got %0d", out_if.tile_index);
        failures++;
      end else begin
        want = expected_tiles[0];
        expected_tiles.delete(0);
        if (out_if.tile_index !== want.tile_index) begin
          $error("tile_index: expected %0d, got %0d", want.tile_index, out_if.tile_index);
          failures++;
        end
        if (out_if.motion_flag !== want.motion_flag) begin
          $error("motion_flag: expected %0d, got %0d", want.motion_flag, out_if.motion_flag);
          failures++;
        end
        if (out_if.last_tile !== want.last_tile) begin
          $error("last_tile: expected %0d, got %0d", want.last_tile, out_if.last_tile);
          failures++;
        end
      end
    end
  end

  // covers the clearing pass after reset with margin
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
